[src/tiak_pkg.sv]
// ----------------------------------------------------------------------------
// tiak_pkg: shared types and constants of the trapezoid arctan integrator
// Fixed-point formats, datapath widths, sequencer states and register indexes.
// ----------------------------------------------------------------------------
`timescale 1ns / 1ps

package tiak_pkg;

  // Number formats
  localparam int unsigned FRAC_BITS  = 36;
  localparam int unsigned COUNT_BITS = 24;
  localparam int unsigned VAL_W      = 42;   // Q6.36 operand / result word
  localparam int unsigned CNT_W      = 25;   // interval count register
  localparam int unsigned SUM_W      = 64;   // running sum of samples

  // Shared multiplier: SUM_W x VAL_W product from four partial products
  localparam int unsigned PROD_W     = SUM_W + VAL_W;
  localparam int unsigned MA_CHUNK   = SUM_W / 2;
  localparam int unsigned MB_CHUNK   = VAL_W / 2;
  localparam int unsigned PP_W       = MA_CHUNK + MB_CHUNK;
  localparam int unsigned SH_W       = $clog2(MA_CHUNK + MB_CHUNK + 1);
  localparam int unsigned MCNT_W     = 3;
  localparam int unsigned MUL_STEPS  = 4;

  // Restoring divider for 2^(2F+2) / (1 + x^2)
  localparam int unsigned DEN_CAP_BIT = 60;
  localparam int unsigned DEN_W       = DEN_CAP_BIT + 1;
  localparam int unsigned REM_W       = DEN_CAP_BIT;
  localparam int unsigned SQ_W        = PROD_W - FRAC_BITS;
  localparam int unsigned DIV_TOP     = 2 * FRAC_BITS + 2;
  localparam int unsigned DCNT_W      = $clog2(DIV_TOP + 1);

  localparam logic [DEN_W-1:0] DEN_CAP  = DEN_W'(1) << DEN_CAP_BIT;
  localparam logic [DEN_W-1:0] DEN_ONE  = DEN_W'(1) << FRAC_BITS;
  localparam logic [CNT_W-1:0] CNT_LIMIT = CNT_W'(1) << COUNT_BITS;

  // APB data width (registers wider than 32 bits)
  localparam int unsigned APB_DW = 64;
  localparam int unsigned APB_AW = 4;

  typedef enum logic {
    REG_STEP_WIDTH     = 1'b0,
    REG_INTERVAL_COUNT = 1'b1
  } reg_idx_e;

  typedef enum logic [2:0] {
    ST_IDLE,
    ST_MUL,
    ST_DEN,
    ST_DIV,
    ST_ACC,
    ST_NEXT,
    ST_FIN,
    ST_DONE
  } state_e;

  typedef enum logic [1:0] {
    PH_A,     // f at the start point
    PH_B,     // f at the end point
    PH_IN,    // interior sample
    PH_FIN    // final product sum * h
  } phase_e;

endpackage

[src/trapezoid_integrate_arctan_kernel.sv]
// ----------------------------------------------------------------------------
// trapezoid_integrate_arctan_kernel: trapezoid integral of 4/(1+x^2)
// Sequenced datapath around one shared multiplier and one restoring divider.
// ----------------------------------------------------------------------------
// Usage:
//   Program step_width (h, Q6.36, byte address 0) and interval_count (n,
//   address 8) over the APB port while the block is idle. Each input transfer
//   carries start_point and end_point; the block returns one output transfer
//   with integral_value (Q6.36) and a saturated flag.
//   Each f sample runs x^2 on the shared 32x21 multiplier, forms the
//   denominator, runs 75 divider iterations (one quotient bit a cycle),
//   accumulates and steps. A request with n >= 1 evaluates n+1 samples and
//   then scales the trapezoid sum by h; n = 0 gives zero. n is clamped to
//   2^24. in_stall_o is high for the whole request, so one request is in
//   flight at a time.
//   The result sits in an output register; while out_stall_i holds it, the
//   block still accepts and computes the next request, then waits with the
//   new result until the output register frees.
//   Reset clears both registers, the sequencer and the output valid.
// ----------------------------------------------------------------------------
`timescale 1ns / 1ps

module trapezoid_integrate_arctan_kernel
  import tiak_pkg::*;
(
  input  logic                clk_i,
  input  logic                rst_ni,
  // APB configuration port
  input  logic                psel,
  input  logic                penable,
  input  logic                pwrite,
  input  logic [APB_AW-1:0]   paddr,
  input  logic [APB_DW-1:0]   pwdata,
  output logic [APB_DW-1:0]   prdata,
  output logic                pready,
  // Request channel
  input  logic                in_valid_i,
  output logic                in_stall_o,
  input  logic [VAL_W-1:0]    start_point_i,
  input  logic [VAL_W-1:0]    end_point_i,
  // Result channel
  output logic                out_valid_o,
  input  logic                out_stall_i,
  output logic [VAL_W-1:0]    integral_value_o,
  output logic                saturated_o
);

  // Configuration registers
  logic [VAL_W-1:0] step_width_q;
  logic [CNT_W-1:0] interval_count_q;

  // Sequencer
  state_e state_q, state_d;
  phase_e phase_q;
  logic [MCNT_W-1:0] mul_cnt_q;
  logic [DCNT_W-1:0] div_cnt_q;
  logic [CNT_W-1:0]  step_counter_q;
  logic [CNT_W-1:0]  n_q;

  // Datapath
  logic [VAL_W-1:0]  end_q;
  logic [VAL_W-1:0]  sample_position_q;
  logic [SUM_W-1:0]  running_sum_q;
  logic [SUM_W-1:0]  fa_q;
  logic [SUM_W-1:0]  mul_a_q;
  logic [VAL_W-1:0]  mul_b_q;
  logic [PP_W-1:0]   pp_q;
  logic [SH_W-1:0]   pp_sh_q;
  logic [PROD_W-1:0] acc_q;
  logic [DEN_W-1:0]  den_q;
  logic [REM_W-1:0]  rem_q;
  logic [SUM_W-1:0]  quo_q;
  logic [VAL_W-1:0]  res_q;
  logic              res_sat_q;

  // Output register
  logic              out_valid_q;
  logic [VAL_W-1:0]  out_value_q;
  logic              out_sat_q;

  logic in_xfer;
  logic cfg_wr;
  logic out_load;

  assign in_xfer  = in_valid_i && !in_stall_o;
  assign cfg_wr   = psel && penable && pwrite && pready;
  assign out_load = (state_q == ST_DONE) && (!out_valid_q || !out_stall_i);

  // --------------------------------------------------------------------------
  // APB register file
  // --------------------------------------------------------------------------
  assign pready = 1'b1;

  always_comb begin
    unique case (reg_idx_e'(paddr[3]))
      REG_STEP_WIDTH:     prdata = APB_DW'(step_width_q);
      REG_INTERVAL_COUNT: prdata = APB_DW'(interval_count_q);
      default:            prdata = '0;
    endcase
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      step_width_q     <= '0;
      interval_count_q <= '0;
    end else if (cfg_wr) begin
      unique case (reg_idx_e'(paddr[3]))
        REG_STEP_WIDTH:     step_width_q     <= pwdata[VAL_W-1:0];
        REG_INTERVAL_COUNT: interval_count_q <= pwdata[CNT_W-1:0];
        default: ;
      endcase
    end
  end

  // --------------------------------------------------------------------------
  // Shared multiplier step: one 32x21 partial product a cycle
  // --------------------------------------------------------------------------
  logic [MA_CHUNK-1:0] ma_chunk;
  logic [MB_CHUNK-1:0] mb_chunk;
  logic [PP_W-1:0]     pp_d;
  logic [SH_W-1:0]     pp_sh_d;
  logic [PROD_W-1:0]   acc_add;

  always_comb begin
    ma_chunk = mul_cnt_q[1] ? mul_a_q[SUM_W-1:MA_CHUNK] : mul_a_q[MA_CHUNK-1:0];
    mb_chunk = mul_cnt_q[0] ? mul_b_q[VAL_W-1:MB_CHUNK] : mul_b_q[MB_CHUNK-1:0];
    pp_d     = PP_W'(ma_chunk) * PP_W'(mb_chunk);
    pp_sh_d  = (mul_cnt_q[1] ? SH_W'(MA_CHUNK) : SH_W'(0))
             + (mul_cnt_q[0] ? SH_W'(MB_CHUNK) : SH_W'(0));
    acc_add  = acc_q + (PROD_W'(pp_q) << pp_sh_q);
  end

  // --------------------------------------------------------------------------
  // Denominator 1 + x^2, clamped to the cap code
  // --------------------------------------------------------------------------
  logic [SQ_W-1:0]  sq;
  logic [DEN_W-1:0] den_sum;
  logic [DEN_W-1:0] den_d;

  always_comb begin
    sq      = acc_q[PROD_W-1:FRAC_BITS];
    den_sum = DEN_W'(sq[DEN_CAP_BIT-1:0]) + DEN_ONE;
    if (|sq[SQ_W-1:DEN_CAP_BIT]) begin
      den_d = DEN_CAP;
    end else if (den_sum > DEN_CAP) begin
      den_d = DEN_CAP;
    end else begin
      den_d = den_sum;
    end
  end

  // --------------------------------------------------------------------------
  // Restoring divider step: one quotient bit a cycle
  // --------------------------------------------------------------------------
  logic [DEN_W-1:0] rem_sh;
  logic             quo_bit;
  logic [REM_W-1:0] rem_d;

  always_comb begin
    rem_sh  = {rem_q, (div_cnt_q == DCNT_W'(DIV_TOP))};
    quo_bit = (rem_sh >= den_q);
    rem_d   = quo_bit ? REM_W'(rem_sh - den_q) : REM_W'(rem_sh);
  end

  // --------------------------------------------------------------------------
  // Sample accumulation, next sample and final scaling
  // --------------------------------------------------------------------------
  logic [SUM_W:0]     end_sum;
  logic [SUM_W:0]     in_sum;
  logic [CNT_W-1:0]   k_next;
  logic               more_samples;
  logic [VAL_W-1:0]   pos_next;
  logic [SQ_W-1:0]    fin_shift;
  logic               fin_sat;
  logic [CNT_W-1:0]   n_clamped;

  always_comb begin
    end_sum      = {1'b0, fa_q} + {1'b0, quo_q};
    in_sum       = {1'b0, running_sum_q} + {1'b0, quo_q};
    k_next       = step_counter_q + CNT_W'(1);
    more_samples = (k_next < n_q);
    pos_next     = sample_position_q + step_width_q;
    fin_shift    = acc_q[PROD_W-1:FRAC_BITS];
    fin_sat      = |fin_shift[SQ_W-1:VAL_W];
    n_clamped    = (interval_count_q > CNT_LIMIT) ? CNT_LIMIT : interval_count_q;
  end

  // --------------------------------------------------------------------------
  // Next-state logic
  // --------------------------------------------------------------------------
  always_comb begin
    state_d    = state_q;
    in_stall_o = (state_q != ST_IDLE);
    unique case (state_q)
      ST_IDLE: begin
        // Input is never stalled while idle
        if (in_valid_i) begin
          state_d = (n_clamped == '0) ? ST_DONE : ST_MUL;
        end
      end
      ST_MUL: begin
        if (mul_cnt_q == MCNT_W'(MUL_STEPS)) begin
          state_d = (phase_q == PH_FIN) ? ST_FIN : ST_DEN;
        end
      end
      ST_DEN:  state_d = ST_DIV;
      ST_DIV: begin
        if (div_cnt_q == '0) begin
          state_d = ST_ACC;
        end
      end
      ST_ACC:  state_d = ST_NEXT;
      ST_NEXT: state_d = ST_MUL;
      ST_FIN:  state_d = ST_DONE;
      ST_DONE: begin
        if (out_load) begin
          state_d = ST_IDLE;
        end
      end
      default: state_d = ST_IDLE;
    endcase
  end

  // --------------------------------------------------------------------------
  // Control registers
  // --------------------------------------------------------------------------
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q        <= ST_IDLE;
      phase_q        <= PH_A;
      mul_cnt_q      <= '0;
      div_cnt_q      <= '0;
      step_counter_q <= '0;
      n_q            <= '0;
      out_valid_q    <= 1'b0;
    end else begin
      state_q <= state_d;

      // Count multiplier and divider steps
      if (state_q == ST_MUL) begin
        mul_cnt_q <= mul_cnt_q + MCNT_W'(1);
      end else begin
        mul_cnt_q <= '0;
      end
      if (state_q == ST_DEN) begin
        div_cnt_q <= DCNT_W'(DIV_TOP);
      end else if (state_q == ST_DIV) begin
        div_cnt_q <= div_cnt_q - DCNT_W'(1);
      end

      // Load request, then advance phase and sample index
      if (in_xfer) begin
        n_q            <= n_clamped;
        step_counter_q <= '0;
        phase_q        <= PH_A;
      end else if (state_q == ST_NEXT) begin
        if (phase_q == PH_A) begin
          phase_q <= PH_B;
        end else if (more_samples) begin
          phase_q        <= PH_IN;
          step_counter_q <= k_next;
        end else begin
          phase_q <= PH_FIN;
        end
      end

      // Hold the result until the receiver takes it
      if (out_load) begin
        out_valid_q <= 1'b1;
      end else if (!out_stall_i) begin
        out_valid_q <= 1'b0;
      end
    end
  end

  // --------------------------------------------------------------------------
  // Datapath registers
  // --------------------------------------------------------------------------
  always_ff @(posedge clk_i) begin
    // Request load: f(a) goes first
    if (in_xfer) begin
      end_q             <= end_point_i;
      sample_position_q <= start_point_i;
      running_sum_q     <= '0;
      mul_a_q           <= SUM_W'(start_point_i);
      mul_b_q           <= start_point_i;
      acc_q             <= '0;
      res_q             <= '0;
      res_sat_q         <= 1'b0;
    end

    // Multiply: register each partial product, then add it shifted
    if (state_q == ST_MUL) begin
      pp_q    <= pp_d;
      pp_sh_q <= pp_sh_d;
      if (mul_cnt_q != '0) begin
        acc_q <= acc_add;
      end
    end

    // Start the divide
    if (state_q == ST_DEN) begin
      den_q <= den_d;
      rem_q <= '0;
      quo_q <= '0;
    end

    // Divide step
    if (state_q == ST_DIV) begin
      rem_q <= rem_d;
      quo_q <= {quo_q[SUM_W-2:0], quo_bit};
    end

    // Accumulate the sample
    if (state_q == ST_ACC) begin
      unique case (phase_q)
        PH_A:    fa_q          <= quo_q;
        PH_B:    running_sum_q <= end_sum[SUM_W:1];
        PH_IN:   running_sum_q <= in_sum[SUM_W] ? '1 : in_sum[SUM_W-1:0];
        PH_FIN:  ;
        default: ;
      endcase
    end

    // Pick the next multiplier operands
    if (state_q == ST_NEXT) begin
      acc_q <= '0;
      if (phase_q == PH_A) begin
        mul_a_q <= SUM_W'(end_q);
        mul_b_q <= end_q;
      end else if (more_samples) begin
        sample_position_q <= pos_next;
        mul_a_q           <= SUM_W'(pos_next);
        mul_b_q           <= pos_next;
      end else begin
        mul_a_q <= running_sum_q;
        mul_b_q <= step_width_q;
      end
    end

    // Scale and saturate
    if (state_q == ST_FIN) begin
      res_q     <= fin_sat ? '1 : fin_shift[VAL_W-1:0];
      res_sat_q <= fin_sat;
    end

    if (out_load) begin
      out_value_q <= res_q;
      out_sat_q   <= res_sat_q;
    end
  end

  assign out_valid_o      = out_valid_q;
  assign integral_value_o = out_value_q;
  assign saturated_o      = out_sat_q;

  // --------------------------------------------------------------------------
  // Assertions
  // --------------------------------------------------------------------------
  a_out_from_done: assert property (@(posedge clk_i) disable iff (!rst_ni)
    $rose(out_valid_o) |-> $past(state_q == ST_DONE))
    else $error("result appeared without a finished request");

  a_xfer_leaves_idle: assert property (@(posedge clk_i) disable iff (!rst_ni)
    in_xfer |=> (state_q != ST_IDLE))
    else $error("sequencer stayed idle after a request transfer");

  a_div_nonzero: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (state_q == ST_DIV) |-> (den_q >= DEN_ONE && den_q <= DEN_CAP))
    else $error("divisor out of range");

  a_interior_bound: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (state_q == ST_MUL && phase_q == PH_IN) |-> (step_counter_q < n_q))
    else $error("interior sample index beyond interval count");

  a_sat_value: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (out_valid_o && saturated_o) |-> (integral_value_o == '1))
    else $error("saturated result not clamped to full scale");

endmodule

[tb/testbench.sv]
// ----------------------------------------------------------------------------
// testbench: self-checking bench for trapezoid_integrate_arctan_kernel
// Programs step width and interval count over APB, then sends a directed table
// of requests followed by random phases, one register setting per phase. Each
// request's expectation, known for some directed rows, else predicted in fixed
// point, is queued at acceptance; each result transfer is checked against the
// oldest. Random gaps on both channels, one long output hold-off, full drains.
// ----------------------------------------------------------------------------
`timescale 1ns / 1ps

module testbench;
  import tiak_pkg::*;

  localparam time         HALF_PERIOD = 10;
  localparam longint      TIMEOUT_NS  = 60_000_000;
  localparam int          LONG_HOLD   = 3000;
  localparam int          SETTLE      = 200;
  localparam int          END_LIMIT   = 2_000_000;
  localparam int          ADDR_SHIFT  = 3;
  localparam int          NUM_ROWS    = 13;
  localparam int          NUM_PHASES  = 6;
  localparam logic [VAL_W-1:0] VAL_MAX = {VAL_W{1'b1}};
  localparam logic [VAL_W-1:0] ONE_Q   = VAL_W'(1) << FRAC_BITS;

  typedef struct packed {
    logic [VAL_W-1:0] value;
    logic             sat;
  } integral_t;

  typedef struct packed {
    logic [VAL_W-1:0] step_h;
    logic [CNT_W-1:0] count_n;
    logic [VAL_W-1:0] start_x;
    logic [VAL_W-1:0] end_x;
    logic             known;
    logic [VAL_W-1:0] known_value;
    logic             known_sat;
  } request_row_t;

  logic                clk_i;
  logic                rst_ni;
  logic                psel;
  logic                penable;
  logic                pwrite;
  logic [APB_AW-1:0]   paddr;
  logic [APB_DW-1:0]   pwdata;
  logic [APB_DW-1:0]   prdata;
  logic                pready;
  logic                in_valid_i;
  logic                in_stall_o;
  logic [VAL_W-1:0]    start_point_i;
  logic [VAL_W-1:0]    end_point_i;
  logic                out_valid_o;
  logic                out_stall_i;
  logic [VAL_W-1:0]    integral_value_o;
  logic                saturated_o;

  // Predictor copies of the registers and of the datapath state
  logic [VAL_W-1:0]    cfg_h;
  logic [CNT_W-1:0]    cfg_n;
  logic [VAL_W-1:0]    probe_x;
  logic [SUM_W-1:0]    sample_sum;
  logic [CNT_W-1:0]    sample_idx;

  integral_t           integral_q[$];
  int                  error_count;
  int                  requests_sent;
  int                  results_seen;
  int                  saturated_seen;
  int                  settings_used;
  logic                free_run;
  logic                long_hold_req;
  request_row_t        directed_rows [NUM_ROWS];

  trapezoid_integrate_arctan_kernel DUT (
    .clk_i            (clk_i),
    .rst_ni           (rst_ni),
    .psel             (psel),
    .penable          (penable),
    .pwrite           (pwrite),
    .paddr            (paddr),
    .pwdata           (pwdata),
    .prdata           (prdata),
    .pready           (pready),
    .in_valid_i       (in_valid_i),
    .in_stall_o       (in_stall_o),
    .start_point_i    (start_point_i),
    .end_point_i      (end_point_i),
    .out_valid_o      (out_valid_o),
    .out_stall_i      (out_stall_i),
    .integral_value_o (integral_value_o),
    .saturated_o      (saturated_o)
  );

  // Clock
  initial clk_i = 1'b0;
  always #(HALF_PERIOD) clk_i = ~clk_i;

  // f(x) = 4 / (1 + x^2): truncated square, capped denominator, truncated quotient
  function automatic logic [SUM_W-1:0] arctan_slope(input logic [VAL_W-1:0] x);
    logic [2*VAL_W-1:0] sq;
    logic [DEN_W-1:0]   den;
    logic [DIV_TOP:0]   num;
    logic [DIV_TOP:0]   quo;
    sq = {{VAL_W{1'b0}}, x} * {{VAL_W{1'b0}}, x};
    sq = sq >> FRAC_BITS;
    if (sq >= DEN_CAP) begin
      den = DEN_CAP;
    end else begin
      den = sq[DEN_W-1:0] + DEN_ONE;
      if (den > DEN_CAP) begin
        den = DEN_CAP;
      end
    end
    num = '0;
    num[DIV_TOP] = 1'b1;
    quo = num / den;
    return quo[SUM_W-1:0];
  endfunction

  // Trapezoid sum over the programmed count and step, then scale by the step
  function automatic integral_t predict_integral(input logic [VAL_W-1:0] a,
                                                 input logic [VAL_W-1:0] b);
    integral_t                  res;
    logic [CNT_W-1:0]           count;
    logic [SUM_W:0]             wide;
    logic [SUM_W+VAL_W-1:0]     prod;
    int unsigned                k;
    count = (cfg_n > CNT_LIMIT) ? CNT_LIMIT : cfg_n;
    probe_x    = a;
    sample_sum = '0;
    sample_idx = '0;
    res = '0;
    if (count == 0) begin
      return res;
    end
    wide = {1'b0, arctan_slope(a)} + {1'b0, arctan_slope(b)};
    sample_sum = wide[SUM_W:1];
    for (k = 1; k < count; k++) begin
      probe_x = probe_x + cfg_h;
      wide = {1'b0, sample_sum} + {1'b0, arctan_slope(probe_x)};
      sample_sum = wide[SUM_W] ? {SUM_W{1'b1}} : wide[SUM_W-1:0];
      sample_idx = CNT_W'(k);
    end
    prod = {{VAL_W{1'b0}}, sample_sum} * {{SUM_W{1'b0}}, cfg_h};
    prod = prod >> FRAC_BITS;
    if (prod > VAL_MAX) begin
      res.value = VAL_MAX;
      res.sat   = 1'b1;
    end else begin
      res.value = prod[VAL_W-1:0];
    end
    return res;
  endfunction

  // Idle length: mostly none or short, a few long; none in free-run phases
  function automatic int pick_gap();
    int r;
    r = $urandom_range(0, 99);
    if (free_run || r < 50) begin
      return 0;
    end else if (r < 90) begin
      return $urandom_range(1, 3);
    end
    return $urandom_range(10, 40);
  endfunction

  // Operand mix: full range, the interesting span below 2.0, and both ends
  function automatic logic [VAL_W-1:0] rand_point();
    int r;
    r = $urandom_range(0, 9);
    if (r < 4) begin
      return VAL_W'({$urandom, $urandom});
    end else if (r < 8) begin
      return VAL_W'({$urandom_range(0, 31), $urandom});
    end else if (r == 8) begin
      return '0;
    end
    return VAL_MAX;
  endfunction

  // APB write: setup then access phase, register written when pready is high
  task automatic apb_write(input reg_idx_e idx, input logic [APB_DW-1:0] data);
    psel    = 1'b1;
    pwrite  = 1'b1;
    penable = 1'b0;
    paddr   = APB_AW'(idx) << ADDR_SHIFT;
    pwdata  = data;
    @(negedge clk_i);
    penable = 1'b1;
    do @(posedge clk_i); while (!pready);
    @(negedge clk_i);
    psel    = 1'b0;
    penable = 1'b0;
    pwrite  = 1'b0;
    unique case (idx)
      REG_STEP_WIDTH:     cfg_h = data[VAL_W-1:0];
      REG_INTERVAL_COUNT: cfg_n = data[CNT_W-1:0];
      default: ;
    endcase
  endtask

  // APB read and compare with the expected register contents
  task automatic check_reg(input reg_idx_e idx, input logic [APB_DW-1:0] want);
    logic [APB_DW-1:0] got;
    psel    = 1'b1;
    pwrite  = 1'b0;
    penable = 1'b0;
    paddr   = APB_AW'(idx) << ADDR_SHIFT;
    @(negedge clk_i);
    penable = 1'b1;
    do @(posedge clk_i); while (!pready);
    got = prdata;
    @(negedge clk_i);
    psel    = 1'b0;
    penable = 1'b0;
    if (got !== want) begin
      $error("register %s readback: expected %h, got %h", idx.name(), want, got);
      error_count++;
    end
  endtask

  // Hold the request channel idle until every pending result has come back
  task automatic drain_results();
    in_valid_i = 1'b0;
    while (integral_q.size() != 0) @(negedge clk_i);
  endtask

  // Reprogram both registers with the block idle
  task automatic program_setting(input logic [VAL_W-1:0] h, input logic [CNT_W-1:0] n);
    drain_results();
    apb_write(REG_STEP_WIDTH, APB_DW'(h));
    apb_write(REG_INTERVAL_COUNT, APB_DW'(n));
    settings_used++;
  endtask

  // Offer one request, hold it through stalls, queue its expected integral
  task automatic send_request(input logic [VAL_W-1:0] a, input logic [VAL_W-1:0] b,
                              input logic known, input integral_t known_res);
    int gap;
    gap = pick_gap();
    if (gap > 0) begin
      in_valid_i = 1'b0;
      repeat (gap) @(negedge clk_i);
    end
    start_point_i = a;
    end_point_i   = b;
    in_valid_i    = 1'b1;
    do @(posedge clk_i); while (in_stall_o);
    @(negedge clk_i);
    integral_q.push_back(known ? known_res : predict_integral(a, b));
    requests_sent++;
  endtask

  // Result channel: random stalls, plus one long hold-off on request
  initial begin : result_stall
    int stall_left;
    int hold_left;
    stall_left  = 0;
    hold_left   = 0;
    out_stall_i = 1'b0;
    forever begin
      @(negedge clk_i);
      if (hold_left > 0) begin
        hold_left--;
        out_stall_i = 1'b1;
      end else if (long_hold_req) begin
        long_hold_req = 1'b0;
        hold_left     = LONG_HOLD - 1;
        out_stall_i   = 1'b1;
      end else if (stall_left > 0) begin
        stall_left--;
        out_stall_i = 1'b1;
      end else begin
        stall_left  = pick_gap();
        out_stall_i = (stall_left > 0);
        if (stall_left > 0) begin
          stall_left--;
        end
      end
    end
  end

  // Check each result transfer against the oldest expectation
  always @(posedge clk_i) begin : check_results
    integral_t want;
    if (rst_ni && out_valid_o && !out_stall_i) begin
      if (integral_q.size() == 0) begin
        $error("result with no request pending: integral_value %h saturated %b",
               integral_value_o, saturated_o);
        error_count++;
      end else begin
        want = integral_q.pop_front();
        results_seen++;
        if (saturated_o) begin
          saturated_seen++;
        end
        if (integral_value_o !== want.value) begin
          $error("integral_value mismatch: expected %h, got %h",
                 want.value, integral_value_o);
          error_count++;
        end
        if (saturated_o !== want.sat) begin
          $error("saturated mismatch: expected %b, got %b", want.sat, saturated_o);
          error_count++;
        end
      end
    end
  end

  // Run limit
  initial begin : run_limit
    #(TIMEOUT_NS);
    $display("status: fail");
    $finish;
  end

  // Stimulus
  initial begin : stimulus
    request_row_t     row;
    integral_t        res;
    logic [VAL_W-1:0] h;
    logic [CNT_W-1:0] n;
    int               items;
    int               guard;

    rst_ni        = 1'b0;
    psel          = 1'b0;
    penable       = 1'b0;
    pwrite        = 1'b0;
    paddr         = '0;
    pwdata        = '0;
    in_valid_i    = 1'b0;
    start_point_i = '0;
    end_point_i   = '0;
    free_run      = 1'b0;
    long_hold_req = 1'b0;
    cfg_h         = '0;
    cfg_n         = '0;
    probe_x       = '0;
    sample_sum    = '0;
    sample_idx    = '0;
    error_count   = 0;
    requests_sent = 0;
    results_seen  = 0;
    saturated_seen = 0;
    settings_used = 0;

    // Directed rows: step, count, start, end, known result or predicted
    directed_rows = '{
      '{'0,         0,  '0,           '0,                 1'b1, '0,    1'b0},
      '{'0,         0,  VAL_MAX,      VAL_MAX,            1'b1, '0,    1'b0},
      '{ONE_Q,      1,  '0,           '0,                 1'b1, ONE_Q << 2, 1'b0},
      '{ONE_Q,      1,  VAL_MAX,      VAL_MAX,            1'b0, '0,    1'b0},
      '{VAL_MAX,    1,  '0,           '0,                 1'b1, VAL_MAX, 1'b1},
      '{VAL_MAX,    3,  VAL_MAX,      '0,                 1'b0, '0,    1'b0},
      '{'0,         5,  ONE_Q,        '0,                 1'b1, '0,    1'b0},
      '{ONE_Q >> 4, 16, '0,           ONE_Q,              1'b0, '0,    1'b0},
      '{VAL_W'(1),  2,  '0,           VAL_MAX,            1'b0, '0,    1'b0},
      '{VAL_W'(1) << 40, 4, VAL_W'(1) << 41, (VAL_W'(1) << 41) + 1, 1'b0, '0, 1'b0},
      '{VAL_MAX,    0,  VAL_MAX,      '0,                 1'b1, '0,    1'b0},
      '{ONE_Q >> 6, 64, '0,           ONE_Q,              1'b0, '0,    1'b0},
      '{ONE_Q >> 6, 64, ONE_Q,        '0,                 1'b0, '0,    1'b0}
    };

    // Reset
    repeat (5) @(negedge clk_i);
    rst_ni = 1'b1;
    @(negedge clk_i);

    // Registers come out of reset cleared
    check_reg(REG_STEP_WIDTH, '0);
    check_reg(REG_INTERVAL_COUNT, '0);

    // Directed table; reprogram only when a row changes the setting
    for (int i = 0; i < NUM_ROWS; i++) begin
      row = directed_rows[i];
      if (row.step_h != cfg_h || row.count_n != cfg_n) begin
        program_setting(row.step_h, row.count_n);
      end
      res.value = row.known_value;
      res.sat   = row.known_sat;
      send_request(row.start_x, row.end_x, row.known, res);
    end

    // Register extremes; counts this large take far too long to run a request
    drain_results();
    apb_write(REG_INTERVAL_COUNT, APB_DW'({CNT_W{1'b1}}));
    check_reg(REG_INTERVAL_COUNT, APB_DW'({CNT_W{1'b1}}));
    apb_write(REG_INTERVAL_COUNT, APB_DW'(CNT_LIMIT));
    check_reg(REG_INTERVAL_COUNT, APB_DW'(CNT_LIMIT));
    apb_write(REG_STEP_WIDTH, APB_DW'(VAL_MAX));
    check_reg(REG_STEP_WIDTH, APB_DW'(VAL_MAX));

    // Random phases, one register setting each
    for (int p = 0; p < NUM_PHASES; p++) begin
      items = 18;
      unique case (p)
        0: begin
          h = VAL_W'({$urandom, $urandom});
          n = CNT_W'($urandom_range(1, 8));
        end
        1: begin
          h = (ONE_Q >> $urandom_range(2, 8)) + VAL_W'($urandom_range(0, 65535));
          n = CNT_W'($urandom_range(8, 24));
        end
        2: begin
          h = VAL_MAX;
          n = CNT_W'($urandom_range(1, 4));
          items = 16;
        end
        3: begin
          h = VAL_W'({$urandom, $urandom});
          n = '0;
          items = 16;
        end
        4: begin
          h = VAL_W'({$urandom, $urandom}) >> $urandom_range(0, 12);
          n = CNT_W'(1);
        end
        default: begin
          h = (ONE_Q >> 9) + VAL_W'($urandom_range(0, 4095));
          n = CNT_W'($urandom_range(300, 600));
          items = 4;
        end
      endcase
      program_setting(h, n);
      free_run = (p == 4);
      if (p == 0) begin
        long_hold_req = 1'b1;
      end
      for (int i = 0; i < items; i++) begin
        if (p == 1 && i == items / 2) begin
          drain_results();
        end
        send_request(rand_point(), rand_point(), 1'b0, '0);
      end
    end

    // Wait out the remaining results, then allow for stray transfers
    in_valid_i = 1'b0;
    free_run   = 1'b0;
    guard = 0;
    while (integral_q.size() != 0 && guard < END_LIMIT) begin
      @(negedge clk_i);
      guard++;
    end
    repeat (SETTLE) @(negedge clk_i);
    if (integral_q.size() != 0) begin
      $error("%0d expected results never arrived", integral_q.size());
      error_count++;
    end

    $display("covered %0d requests under %0d register settings plus register extremes",
             requests_sent, settings_used);
    $display("checked %0d results, %0d of them saturated; %0d errors",
             results_seen, saturated_seen, error_count);
    if (error_count == 0) begin
      $display("status: pass");
    end else begin
      $display("status: fail");
    end
    $finish;
  end

endmodule
